### rtl/msc_pkg.sv
// Shared constants, types and the microcode ROM of the MIPS subset core.
package msc_pkg;

	// Unified word memory; the depth is a power of two, so the word index wraps by truncation.
	localparam int unsigned MEM_WORDS = 4096;
	localparam int unsigned MEM_AW = $clog2(MEM_WORDS);

	// Special instruction words and address masks.
	localparam logic [31:0] SYSCALL_WORD = 32'h0000_000c;
	localparam logic [31:0] JUMP_REGION = 32'hF000_0000;

	// Syscall services that the core acts on.
	localparam logic [31:0] SVC_RD_INT = 32'd5;
	localparam logic [31:0] SVC_RD_FLT = 32'd6;
	localparam logic [31:0] SVC_EXIT = 32'd10;
	localparam logic [31:0] SVC_RD_CHR = 32'd12;

	// Fixed register numbers.
	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_V0 = 5'd2;
	localparam logic [4:0] REG_A0 = 5'd4;

	// Primary opcodes.
	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J = 6'h02;
	localparam logic [5:0] OP_BEQ = 6'h04;
	localparam logic [5:0] OP_ADDI = 6'h08;
	localparam logic [5:0] OP_ORI = 6'h0D;
	localparam logic [5:0] OP_LUI = 6'h0F;
	localparam logic [5:0] OP_LW = 6'h23;
	localparam logic [5:0] OP_SW = 6'h2B;

	// R-type function codes.
	localparam logic [5:0] FUNCT_ADD = 6'h20;
	localparam logic [5:0] FUNCT_SUB = 6'h22;
	localparam logic [5:0] FUNCT_SLT = 6'h2A;

	// Host command codes carried in the func field.
	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_SETPC = 3'd1;
	localparam logic [2:0] CMD_EXEC = 3'd2;
	localparam logic [2:0] CMD_RDREG = 3'd3;
	localparam logic [2:0] CMD_RDMEM = 3'd4;

	// Microcode addresses.
	localparam int unsigned UPC_W = 4;
	localparam logic [UPC_W-1:0] UA_IDLE = 4'd0;
	localparam logic [UPC_W-1:0] UA_WRW = 4'd1;
	localparam logic [UPC_W-1:0] UA_SETPC = 4'd2;
	localparam logic [UPC_W-1:0] UA_RDR1 = 4'd3;
	localparam logic [UPC_W-1:0] UA_RDR2 = 4'd4;
	localparam logic [UPC_W-1:0] UA_RDM1 = 4'd5;
	localparam logic [UPC_W-1:0] UA_RDM2 = 4'd6;
	localparam logic [UPC_W-1:0] UA_FETCH = 4'd7;
	localparam logic [UPC_W-1:0] UA_DECODE = 4'd8;
	localparam logic [UPC_W-1:0] UA_EXEC = 4'd9;
	localparam logic [UPC_W-1:0] UA_MEMACC = 4'd10;
	localparam logic [UPC_W-1:0] UA_LOADWB = 4'd11;
	localparam logic [UPC_W-1:0] UA_RESP = 4'd12;

	// Jump kinds. IF kinds go to the target if their condition holds, WAIT_OUT if unblocked.
	localparam logic [2:0] JK_NEXT = 3'd0;
	localparam logic [2:0] JK_GOTO = 3'd1;
	localparam logic [2:0] JK_DISPATCH = 3'd2;
	localparam logic [2:0] JK_IF_HALT = 3'd3;
	localparam logic [2:0] JK_IF_ALU = 3'd4;
	localparam logic [2:0] JK_IF_STORE = 3'd5;
	localparam logic [2:0] JK_WAIT_OUT = 3'd6;

	// Memory port operations.
	localparam logic [2:0] MO_NONE = 3'd0;
	localparam logic [2:0] MO_RD_IN = 3'd1;
	localparam logic [2:0] MO_WR_IN = 3'd2;
	localparam logic [2:0] MO_RD_PC = 3'd3;
	localparam logic [2:0] MO_ACC = 3'd4;

	// Register file read address sources.
	localparam logic [1:0] RS_NONE = 2'd0;
	localparam logic [1:0] RS_IDX = 2'd1;
	localparam logic [1:0] RS_DEC = 2'd2;

	// Sources for the host read data register.
	localparam logic [1:0] RL_NONE = 2'd0;
	localparam logic [1:0] RL_RF = 2'd1;
	localparam logic [1:0] RL_MEM = 2'd2;

	// One microcode word.
	typedef struct packed {
		logic [2:0]       jmp;
		logic [UPC_W-1:0] target;
		logic [2:0]       mem_op;
		logic [1:0]       rf_op;
		logic [1:0]       rd_op;
		logic             ld_ir;
		logic             ex;
		logic             wb_load;
		logic             set_pc;
		logic             out_ld;
	} ucw_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic accept;
		ucw_t uw;
	} ctrl_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic halt;
		logic alu_only;
		logic store;
		logic out_block;
		logic mem_busy;
	} stat_t;

	// Request to the word memory.
	typedef struct packed {
		logic              en;
		logic              we;
		logic [MEM_AW-1:0] idx;
		logic [31:0]       wdata;
	} mem_req_t;

	// Microcode ROM.
	function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] upc);
		ucw_t w;
		w = '0;
		w.jmp = JK_GOTO;
		w.target = UA_IDLE;
		case (upc)
			UA_IDLE: begin
				w.jmp = JK_DISPATCH;
			end
			UA_WRW: begin
				w.mem_op = MO_WR_IN;
				w.target = UA_RESP;
			end
			UA_SETPC: begin
				w.set_pc = 1'b1;
				w.target = UA_RESP;
			end
			UA_RDR1: begin
				w.rf_op = RS_IDX;
				w.jmp = JK_NEXT;
			end
			UA_RDR2: begin
				w.rd_op = RL_RF;
				w.target = UA_RESP;
			end
			UA_RDM1: begin
				w.mem_op = MO_RD_IN;
				w.jmp = JK_NEXT;
			end
			UA_RDM2: begin
				w.rd_op = RL_MEM;
				w.target = UA_RESP;
			end
			UA_FETCH: begin
				w.mem_op = MO_RD_PC;
				w.jmp = JK_IF_HALT;
				w.target = UA_RESP;
			end
			UA_DECODE: begin
				w.ld_ir = 1'b1;
				w.rf_op = RS_DEC;
				w.jmp = JK_NEXT;
			end
			UA_EXEC: begin
				w.ex = 1'b1;
				w.jmp = JK_IF_ALU;
				w.target = UA_RESP;
			end
			UA_MEMACC: begin
				w.mem_op = MO_ACC;
				w.jmp = JK_IF_STORE;
				w.target = UA_RESP;
			end
			UA_LOADWB: begin
				w.wb_load = 1'b1;
				w.jmp = JK_NEXT;
			end
			UA_RESP: begin
				w.out_ld = 1'b1;
				w.jmp = JK_WAIT_OUT;
				w.target = UA_IDLE;
			end
			default: begin
				w.jmp = JK_GOTO;
			end
		endcase
		return w;
	endfunction

	// Entry point of the routine for each host command.
	function automatic logic [UPC_W-1:0] entry_of(input logic [2:0] func);
		logic [UPC_W-1:0] e;
		case (func)
			CMD_WRITE: e = UA_WRW;
			CMD_SETPC: e = UA_SETPC;
			CMD_EXEC:  e = UA_FETCH;
			CMD_RDREG: e = UA_RDR1;
			CMD_RDMEM: e = UA_RDM1;
			default:   e = UA_RESP;
		endcase
		return e;
	endfunction

endpackage

### rtl/msc_if.sv
// Valid/ready channel interfaces for the host command and result streams.
interface msc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [31:0] addr;
	logic [4:0]  reg_index;
	logic [31:0] data;

	modport source(output valid, output func, output addr, output reg_index, output data,
		input ready);
	modport sink(input valid, input func, input addr, input reg_index, input data,
		output ready);
endinterface

interface msc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] pc_now;
	logic        halted;
	logic [31:0] read_data;
	logic        service_valid;
	logic [31:0] service_code;
	logic [31:0] service_arg;

	modport source(output valid, output pc_now, output halted, output read_data,
		output service_valid, output service_code, output service_arg, input ready);
	modport sink(input valid, input pc_now, input halted, input read_data,
		input service_valid, input service_code, input service_arg, output ready);
endinterface

### rtl/msc_regfile.sv
// General register file: two registered read ports, one write port, per-entry valid bits.
module msc_regfile import msc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        re,
	input  logic [4:0]  ra,
	input  logic [4:0]  rb,
	input  logic        we,
	input  logic [4:0]  wa,
	input  logic [31:0] wd,
	output logic [31:0] rd_a,
	output logic [31:0] rd_b
);

	logic [31:0] regs [32];
	logic [31:0] vld_q;
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;
	logic        wr_ok;

	// Register zero is never written, so its valid bit stays clear and it reads zero.
	assign wr_ok = we && (wa != REG_ZERO);

	// Valid bits: an entry never written reads as its reset value of zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_ok) begin
			vld_q[wa] <= 1'b1;
		end
	end

	// Storage write and registered reads; read outputs hold until the next read.
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			regs[wa] <= wd;
		end
		if (re) begin
			rd_a_q <= vld_q[ra] ? regs[ra] : '0;
			rd_b_q <= vld_q[rb] ? regs[rb] : '0;
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

### rtl/msc_mem.sv
// Unified single-port word memory with a clearing pass after reset.
module msc_mem import msc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mem_req_t    req,
	output logic [31:0] rdata,
	output logic        busy
);

	logic [31:0]       mem [MEM_WORDS];
	logic [31:0]       rdata_q;
	logic [MEM_AW-1:0] clr_idx_q;
	logic              clr_q;

	// Clearing pass: one word per cycle from index zero to the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + MEM_AW'(1);
			if (clr_idx_q == MEM_AW'(MEM_WORDS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Single port: either the clearing write, a request write, or a registered read.
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (req.en && req.we) begin
			mem[req.idx] <= req.wdata;
		end
		if (req.en && !req.we) begin
			rdata_q <= mem[req.idx];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_q;

endmodule

### rtl/msc_ucode.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
module msc_ucode import msc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] in_func,
	output logic       in_ready,
	input  stat_t      stat,
	output ctrl_t      ctrl
);

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;
	logic [UPC_W-1:0] upc_inc;
	ucw_t             uw;
	logic             accept;

	assign uw       = ucode_rom(upc_q);
	assign upc_inc  = upc_q + UPC_W'(1);
	assign in_ready = (upc_q == UA_IDLE) && !stat.mem_busy;
	assign accept   = in_valid && in_ready;

	// Next step selection.
	always_comb begin
		case (uw.jmp)
			JK_NEXT:     upc_nxt = upc_inc;
			JK_GOTO:     upc_nxt = uw.target;
			JK_DISPATCH: upc_nxt = accept ? entry_of(in_func) : upc_q;
			JK_IF_HALT:  upc_nxt = stat.halt ? uw.target : upc_inc;
			JK_IF_ALU:   upc_nxt = stat.alu_only ? uw.target : upc_inc;
			JK_IF_STORE: upc_nxt = stat.store ? uw.target : upc_inc;
			JK_WAIT_OUT: upc_nxt = stat.out_block ? upc_q : uw.target;
			default:     upc_nxt = UA_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

	// The result load waits while the output register still holds an untaken result.
	always_comb begin
		ctrl.accept    = accept;
		ctrl.uw        = uw;
		ctrl.uw.out_ld = uw.out_ld && !stat.out_block;
	end

endmodule

### rtl/msc_dp.sv
// Datapath: PC, halt flag, instruction register, ALU, register file, memory and result register.
module msc_dp import msc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_t       ctrl,
	output stat_t       stat,
	input  logic [31:0] in_addr,
	input  logic [4:0]  in_reg_index,
	input  logic [31:0] in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pc_now,
	output logic        halted,
	output logic [31:0] read_data,
	output logic        service_valid,
	output logic [31:0] service_code,
	output logic [31:0] service_arg
);

	// Architectural and item registers.
	logic [31:0]       pc_q;
	logic              halt_q;
	logic [31:0]       ir_q;
	logic [31:0]       addr_q;
	logic [4:0]        ridx_q;
	logic [31:0]       data_q;
	logic [MEM_AW-1:0] eaddr_q;
	logic [31:0]       rdata_q;
	logic              svc_v_q;
	logic [31:0]       svc_code_q;
	logic [31:0]       svc_arg_q;

	// Result register.
	logic              out_valid_q;
	logic [31:0]       o_pc_q;
	logic              o_halt_q;
	logic [31:0]       o_rdata_q;
	logic              o_sv_q;
	logic [31:0]       o_code_q;
	logic [31:0]       o_arg_q;

	// Instruction fields and operands.
	logic [5:0]        op;
	logic [5:0]        funct;
	logic [4:0]        rt;
	logic [4:0]        rd;
	logic [31:0]       imm_s;
	logic [31:0]       imm_z;
	logic              sys;
	logic [31:0]       a;
	logic [31:0]       b;
	logic [31:0]       sum_ai;

	// Register file and memory connections.
	logic              rf_re;
	logic [4:0]        rf_ra;
	logic [4:0]        rf_rb;
	logic              wb_en;
	logic [4:0]        wb_addr;
	logic [31:0]       wb_data;
	mem_req_t          mreq;
	logic [31:0]       mem_rd;
	logic              mem_busy;

	assign op     = ir_q[31:26];
	assign funct  = ir_q[5:0];
	assign rt     = ir_q[20:16];
	assign rd     = ir_q[15:11];
	assign imm_s  = {{16{ir_q[15]}}, ir_q[15:0]};
	assign imm_z  = {16'h0000, ir_q[15:0]};
	assign sys    = (ir_q == SYSCALL_WORD);
	assign sum_ai = a + imm_s;

	msc_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (rf_re),
		.ra     (rf_ra),
		.rb     (rf_rb),
		.we     (wb_en),
		.wa     (wb_addr),
		.wd     (wb_data),
		.rd_a   (a),
		.rd_b   (b)
	);

	msc_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (mem_rd),
		.busy   (mem_busy)
	);

	// Status for the sequencer.
	always_comb begin
		stat.halt      = halt_q;
		stat.alu_only  = !((op == OP_LW) || (op == OP_SW));
		stat.store     = (op == OP_SW);
		stat.out_block = out_valid_q && !out_ready;
		stat.mem_busy  = mem_busy;
	end

	// Register read addresses: host index, or the fields of the word just fetched.
	// A syscall reads $v0 and $a0 instead.
	always_comb begin
		rf_re = (ctrl.uw.rf_op != RS_NONE);
		rf_ra = ridx_q;
		rf_rb = ridx_q;
		if (ctrl.uw.rf_op == RS_DEC) begin
			if (mem_rd == SYSCALL_WORD) begin
				rf_ra = REG_V0;
				rf_rb = REG_A0;
			end else begin
				rf_ra = mem_rd[25:21];
				rf_rb = mem_rd[20:16];
			end
		end
	end

	// Memory request for the current step.
	always_comb begin
		mreq = '0;
		case (ctrl.uw.mem_op)
			MO_RD_IN: begin
				mreq.en  = 1'b1;
				mreq.idx = addr_q[MEM_AW+1:2];
			end
			MO_WR_IN: begin
				mreq.en    = 1'b1;
				mreq.we    = 1'b1;
				mreq.idx   = addr_q[MEM_AW+1:2];
				mreq.wdata = data_q;
			end
			MO_RD_PC: begin
				mreq.en  = 1'b1;
				mreq.idx = pc_q[MEM_AW+1:2];
			end
			MO_ACC: begin
				mreq.en    = 1'b1;
				mreq.we    = (op == OP_SW);
				mreq.idx   = eaddr_q;
				mreq.wdata = b;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	// Write-back: load data, ALU results and syscall input services.
	always_comb begin
		wb_en   = 1'b0;
		wb_addr = rt;
		wb_data = '0;
		if (ctrl.uw.wb_load) begin
			wb_en   = 1'b1;
			wb_data = mem_rd;
		end else if (ctrl.uw.ex) begin
			if (sys) begin
				wb_addr = REG_A0;
				if (a inside {SVC_RD_INT, SVC_RD_FLT}) begin
					wb_en   = 1'b1;
					wb_data = data_q;
				end else if (a == SVC_RD_CHR) begin
					wb_en   = 1'b1;
					wb_data = {24'h000000, data_q[7:0]};
				end
			end else begin
				case (op)
					OP_LUI: begin
						wb_en   = 1'b1;
						wb_data = {ir_q[15:0], 16'h0000};
					end
					OP_ORI: begin
						wb_en   = 1'b1;
						wb_data = a | imm_z;
					end
					OP_ADDI: begin
						wb_en   = 1'b1;
						wb_data = sum_ai;
					end
					OP_RTYPE: begin
						wb_addr = rd;
						case (funct)
							FUNCT_ADD: begin
								wb_en   = 1'b1;
								wb_data = a + b;
							end
							FUNCT_SUB: begin
								wb_en   = 1'b1;
								wb_data = a - b;
							end
							FUNCT_SLT: begin
								wb_en   = 1'b1;
								wb_data = {31'd0, $signed(a) < $signed(b)};
							end
							default: begin
								wb_en = 1'b0;
							end
						endcase
					end
					default: begin
						wb_en = 1'b0;
					end
				endcase
			end
		end
	end

	// Program counter and halt flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			halt_q <= 1'b0;
		end else begin
			if (ctrl.uw.set_pc) begin
				pc_q   <= {addr_q[31:2], 2'b00};
				halt_q <= 1'b0;
			end
			if (ctrl.uw.ld_ir) begin
				pc_q <= pc_q + 32'd4;
			end
			if (ctrl.uw.ex) begin
				if (sys) begin
					if (a == SVC_EXIT) begin
						halt_q <= 1'b1;
					end
				end else if ((op == OP_BEQ) && (a == b)) begin
					pc_q <= pc_q + {imm_s[29:0], 2'b00};
				end else if (op == OP_J) begin
					pc_q <= (pc_q & JUMP_REGION) | {4'h0, ir_q[25:0], 2'b00};
				end
			end
		end
	end

	// Item registers: input capture, instruction, effective address, read data, service report.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			addr_q  <= in_addr;
			ridx_q  <= in_reg_index;
			data_q  <= in_data;
			rdata_q <= '0;
			svc_v_q <= 1'b0;
			svc_code_q <= '0;
			svc_arg_q  <= '0;
		end
		if (ctrl.uw.ld_ir) begin
			ir_q <= mem_rd;
		end
		if (ctrl.uw.ex) begin
			eaddr_q <= sum_ai[MEM_AW+1:2];
			if (sys) begin
				svc_v_q    <= 1'b1;
				svc_code_q <= a;
				svc_arg_q  <= b;
			end
		end
		case (ctrl.uw.rd_op)
			RL_RF:   rdata_q <= a;
			RL_MEM:  rdata_q <= mem_rd;
			default: ;
		endcase
	end

	// Result register: filled once per item, emptied by a transfer on the result channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.uw.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.uw.out_ld) begin
			o_pc_q    <= pc_q;
			o_halt_q  <= halt_q;
			o_rdata_q <= rdata_q;
			o_sv_q    <= svc_v_q;
			o_code_q  <= svc_code_q;
			o_arg_q   <= svc_arg_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign pc_now        = o_pc_q;
	assign halted        = o_halt_q;
	assign read_data     = o_rdata_q;
	assign service_valid = o_sv_q;
	assign service_code  = o_code_q;
	assign service_arg   = o_arg_q;

endmodule

### rtl/mips_subset_core_step_core.sv
// Top level of the microcoded MIPS subset core with host command and result channels.
//
// The core takes one host command at a time and returns one result for each. After reset
// it clears its 4096-word memory, one word per cycle, and accepts no command meanwhile.
// A command is accepted in the sequencer's idle step; the result is loaded into the
// output register in a final step and shows on the result channel the cycle after.
// Before the final step an unused command runs no step, a memory write or set pc its own
// step, a read a lookup and a capture step, an instruction a fetch, decode and execute
// step (fetch only when halted), a store adds a memory access and a load adds that and a
// write-back. The next command can enter while the loaded result waits to be taken.
// The steps follow from the single memory port, shared by the fetch and the load or
// store, and from the registered reads of the register file and memory.
module mips_subset_core_step_core import msc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	msc_req_if.sink   req,
	msc_rsp_if.source rsp
);

	ctrl_t ctrl;
	stat_t stat;

	msc_ucode u_ucode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_func  (req.func),
		.in_ready (req.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	msc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.in_addr       (req.addr),
		.in_reg_index  (req.reg_index),
		.in_data       (req.data),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.pc_now        (rsp.pc_now),
		.halted        (rsp.halted),
		.read_data     (rsp.read_data),
		.service_valid (rsp.service_valid),
		.service_code  (rsp.service_code),
		.service_arg   (rsp.service_arg)
	);

	// No command may enter while the memory is still being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mem_busy |-> !req.ready)
		else $error("command channel ready during memory clearing pass");

	// A new result never overwrites one that has not been transferred.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.uw.out_ld |-> !(rsp.valid && !rsp.ready))
		else $error("result register loaded while holding an untaken result");

	// The core works on one command at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("command channel ready in the cycle after a transfer");

endmodule

### tb/msc_core_checker.sv
// Channel monitor that models the MIPS subset core and compares every result transfer.
module msc_core_checker import msc_pkg::*; (
	input logic clk,
	input logic arst_n,
	msc_req_if req,
	msc_rsp_if rsp,
	output int unsigned mismatches,
	output int unsigned rsp_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] pc_now;
		logic        halted;
		logic [31:0] read_data;
		logic        service_valid;
		logic [31:0] service_code;
		logic [31:0] service_arg;
	} core_rsp_t;

	// Architectural state of the modeled core.
	logic [31:0] pc_q;
	logic        halt_q;
	logic [31:0] gpr [32];
	logic [31:0] ram [MEM_WORDS];

	// Results still owed by the core, oldest first.
	core_rsp_t rsp_due_q[$];

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// Writes to $zero are dropped.
	function automatic void gpr_write(input logic [4:0] n, input logic [31:0] v);
		if (n != REG_ZERO) begin
			gpr[n] = v;
		end
	endfunction

	// Applies one host command to the model and returns the result it should produce.
	function automatic core_rsp_t core_step(input logic [2:0] func, input logic [31:0] addr,
		input logic [4:0] ridx, input logic [31:0] data);
		core_rsp_t r;
		logic [31:0] ins;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] ea;
		logic [31:0] svc;
		logic [4:0] rs;
		logic [4:0] rt;
		logic [4:0] rd;
		r = '0;
		case (func)
			CMD_WRITE: begin
				ram[addr[MEM_AW+1:2]] = data;
			end
			CMD_SETPC: begin
				pc_q = {addr[31:2], 2'b00};
				halt_q = 1'b0;
			end
			CMD_EXEC: begin
				if (!halt_q) begin
					ins = ram[pc_q[MEM_AW+1:2]];
					rs = ins[25:21];
					rt = ins[20:16];
					rd = ins[15:11];
					a = gpr[rs];
					b = gpr[rt];
					ea = a + sext16(ins[15:0]);
					pc_q = pc_q + 32'd4;
					if (ins == SYSCALL_WORD) begin
						// A syscall reports $v0 and $a0 as they were, then acts on the service.
						svc = gpr[REG_V0];
						r.service_valid = 1'b1;
						r.service_code = svc;
						r.service_arg = gpr[REG_A0];
						if (svc == SVC_RD_INT || svc == SVC_RD_FLT) begin
							gpr_write(REG_A0, data);
						end else if (svc == SVC_RD_CHR) begin
							gpr_write(REG_A0, {24'd0, data[7:0]});
						end else if (svc == SVC_EXIT) begin
							halt_q = 1'b1;
						end
					end else begin
						case (ins[31:26])
							OP_LW: gpr_write(rt, ram[ea[MEM_AW+1:2]]);
							OP_SW: ram[ea[MEM_AW+1:2]] = b;
							OP_LUI: gpr_write(rt, {ins[15:0], 16'd0});
							OP_BEQ: begin
								if (a == b) begin
									pc_q = pc_q + (sext16(ins[15:0]) << 2);
								end
							end
							OP_ORI: gpr_write(rt, a | {16'd0, ins[15:0]});
							OP_ADDI: gpr_write(rt, ea);
							OP_J: pc_q = (pc_q & JUMP_REGION) | {4'd0, ins[25:0], 2'b00};
							OP_RTYPE: begin
								case (ins[5:0])
									FUNCT_ADD: gpr_write(rd, a + b);
									FUNCT_SUB: gpr_write(rd, a - b);
									FUNCT_SLT: gpr_write(rd,
										($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
									default: ;
								endcase
							end
							default: ;
						endcase
					end
				end
			end
			CMD_RDREG: begin
				r.read_data = gpr[ridx];
			end
			CMD_RDMEM: begin
				r.read_data = ram[addr[MEM_AW+1:2]];
			end
			default: ;
		endcase
		r.pc_now = pc_q;
		r.halted = halt_q;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t ns: %s expected %h, got %h", $time, name, want, got);
		end
	endfunction

	// Transfers are sampled at the rising edge; the result side is handled first.
	always @(posedge clk or negedge arst_n) begin
		core_rsp_t want;
		if (!arst_n) begin
			pc_q = '0;
			halt_q = 1'b0;
			for (int i = 0; i < 32; i++) begin
				gpr[i] = '0;
			end
			for (int i = 0; i < MEM_WORDS; i++) begin
				ram[i] = '0;
			end
			rsp_due_q.delete();
			mismatches = 0;
			rsp_due = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (rsp_due_q.size() == 0) begin
					mismatches++;
					$display("%0t ns: result transfer expected none, got pc_now %h", $time,
						rsp.pc_now);
				end else begin
					want = rsp_due_q.pop_front();
					check_field("pc_now", want.pc_now, rsp.pc_now);
					check_field("halted", {31'd0, want.halted}, {31'd0, rsp.halted});
					check_field("read_data", want.read_data, rsp.read_data);
					check_field("service_valid", {31'd0, want.service_valid},
						{31'd0, rsp.service_valid});
					check_field("service_code", want.service_code, rsp.service_code);
					check_field("service_arg", want.service_arg, rsp.service_arg);
				end
			end
			if (req.valid && req.ready) begin
				rsp_due_q.push_back(core_step(req.func, req.addr, req.reg_index, req.data));
			end
			rsp_due = rsp_due_q.size();
		end
	end

endmodule

### tb/mips_subset_core_step_core_tb.sv
// Testbench top: clock, reset, host command stimulus, result back-pressure and the verdict.
module mips_subset_core_step_core_tb import msc_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// Register numbers used by the directed program.
	localparam logic [4:0] R_T0 = 5'd8;
	localparam logic [4:0] R_T1 = 5'd9;
	localparam logic [4:0] R_T3 = 5'd11;

	// A func code the core does not use.
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	localparam int unsigned RANDOM_ITEMS = 1400;

	logic clk = 1'b0;
	logic arst_n;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned host_items;
	int unsigned mismatches;
	int unsigned rsp_due;

	msc_req_if req_ch();
	msc_rsp_if rsp_ch();

	mips_subset_core_step_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	msc_core_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.rsp_due    (rsp_due)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls at random, at the rate of the current phase.
	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
		input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
		input logic [4:0] rd, input logic [5:0] funct);
		return {OP_RTYPE, rs, rt, rd, 5'd0, funct};
	endfunction

	// A byte address of the given word with random upper and low bits.
	function automatic logic [31:0] alias_addr(input int unsigned idx);
		logic [31:0] a;
		a = $urandom();
		a[MEM_AW+1:2] = idx[MEM_AW-1:0];
		return a;
	endfunction

	// Mostly the low registers, so that values get reused; sometimes any register.
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(3) == 0) begin
			return 5'($urandom_range(31));
		end
		return 5'($urandom_range(12));
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(3))
			0: return 16'($urandom_range(15));
			1: return 16'h0000 - 16'($urandom_range(1, 16));
			2: return 16'($urandom());
			default: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'hFFFF;
					default: return 16'h0000;
				endcase
			end
		endcase
	endfunction

	// Presents one command at a falling edge and holds it until the transfer.
	task automatic issue(input logic [2:0] func, input logic [31:0] addr,
		input logic [4:0] ridx, input logic [31:0] data);
		while ($urandom_range(99) < gap_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.func = func;
		req_ch.addr = addr;
		req_ch.reg_index = ridx;
		req_ch.data = data;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		if (func <= CMD_RDMEM) begin
			host_items++;
		end
	endtask

	initial begin
		logic [31:0] prog[$];
		logic [31:0] word;
		logic [15:0] svc16;
		logic [4:0] rs;
		logic [4:0] rt;
		int unsigned base;
		int unsigned len;
		int unsigned steps;
		int unsigned n;

		req_ch.valid = 1'b0;
		req_ch.func = CMD_WRITE;
		req_ch.addr = '0;
		req_ch.reg_index = '0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		gap_pct = 9;
		stall_pct = 60;
		host_items = 0;

		// Reset, released at a falling edge.
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed program: wrapped addresses, signed compare, wrapping add into $zero,
		// store with a negative offset, read-char service, then exit and a halted step.
		issue(CMD_RDMEM, 32'hFFFF_FFFF, 5'd0, 32'd0);
		issue(CMD_WRITE, 32'h0000_4003, 5'd0, enc_i(OP_LUI, REG_ZERO, R_T0, 16'h8000));
		issue(CMD_WRITE, 32'h0000_0004, 5'd0, enc_i(OP_ADDI, REG_ZERO, R_T1, 16'hFFFF));
		issue(CMD_WRITE, 32'h0000_0008, 5'd0, enc_r(R_T0, R_T1, R_T3, FUNCT_SLT));
		issue(CMD_WRITE, 32'h0000_000C, 5'd0, enc_r(R_T0, R_T1, REG_ZERO, FUNCT_ADD));
		issue(CMD_WRITE, 32'h0000_0010, 5'd0, enc_i(OP_SW, REG_ZERO, R_T1, 16'hFFFC));
		issue(CMD_WRITE, 32'h0000_0014, 5'd0, enc_i(OP_ADDI, REG_ZERO, REG_V0, 16'd12));
		issue(CMD_WRITE, 32'h0000_0018, 5'd0, SYSCALL_WORD);
		issue(CMD_WRITE, 32'h0000_001C, 5'd0, enc_i(OP_ADDI, REG_V0, REG_V0, 16'hFFFE));
		issue(CMD_WRITE, 32'h0000_0020, 5'd0, SYSCALL_WORD);
		issue(CMD_SETPC, 32'hA000_0003, 5'd0, 32'd0);
		repeat (10) issue(CMD_EXEC, 32'd0, 5'd0, 32'hFFFF_FFA5);
		issue(CMD_RDREG, 32'd0, R_T3, 32'd0);
		issue(CMD_RDREG, 32'd0, REG_ZERO, 32'd0);
		issue(CMD_RDMEM, 32'hFFFF_FFFC, 5'd0, 32'd0);
		issue(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);

		// Random part: mostly short programs that are loaded, started and stepped,
		// with some fully random commands in between.
		host_items = 0;
		while (host_items < RANDOM_ITEMS) begin
			if (host_items >= 2 * RANDOM_ITEMS / 3) begin
				gap_pct = 0;
				stall_pct = 0;
			end else if (host_items >= RANDOM_ITEMS / 3) begin
				gap_pct = 60;
				stall_pct = 9;
			end
			if ($urandom_range(9) < 8) begin
				base = $urandom_range(MEM_WORDS - 1);
				len = $urandom_range(4, 16);
				prog.delete();
				while (prog.size() < len) begin
					rs = pick_reg();
					rt = pick_reg();
					case ($urandom_range(11))
						0: word = enc_i(OP_LW, rs, rt, pick_imm());
						1: word = enc_i(OP_SW, rs, rt, pick_imm());
						2: word = enc_i(OP_LUI, 5'($urandom_range(31)), rt, pick_imm());
						3: word = enc_i(OP_BEQ, rs, ($urandom_range(1) != 0) ? rs : rt,
							16'($urandom_range(7)) - 16'd3);
						4: word = enc_i(OP_ORI, rs, rt, pick_imm());
						5: word = enc_i(OP_ADDI, rs, rt, pick_imm());
						6: word = enc_r(rs, rt, pick_reg(), FUNCT_ADD);
						7: word = enc_r(rs, rt, pick_reg(), FUNCT_SUB);
						8: word = enc_r(rs, rt, pick_reg(), FUNCT_SLT);
						9: begin
							// Jump back into the program, keeping random upper target bits.
							word = {OP_J, 26'($urandom())};
							word[MEM_AW-1:0] = MEM_AW'(base + $urandom_range(len - 1));
						end
						10: begin
							// Syscall, usually with a service loaded into $v0 just before.
							word = SYSCALL_WORD;
							case ($urandom_range(5))
								0: svc16 = SVC_RD_INT[15:0];
								1: svc16 = SVC_RD_FLT[15:0];
								2: svc16 = SVC_EXIT[15:0];
								3: svc16 = SVC_RD_CHR[15:0];
								default: svc16 = 16'($urandom());
							endcase
							if ($urandom_range(5) != 0) begin
								prog.push_back(enc_i(OP_ADDI, REG_ZERO, REG_V0, svc16));
							end
						end
						default: begin
							if ($urandom_range(1) != 0) begin
								word = $urandom();
							end else begin
								word = enc_r(rs, rt, pick_reg(), 6'($urandom()));
							end
						end
					endcase
					prog.push_back(word);
				end
				foreach (prog[k]) begin
					issue(CMD_WRITE, alias_addr(base + k), 5'($urandom_range(31)), prog[k]);
				end
				issue(CMD_SETPC, alias_addr(base), 5'($urandom_range(31)), $urandom());
				steps = len + $urandom_range(len);
				repeat (steps) begin
					case ($urandom_range(15))
						0: issue(CMD_RDREG, $urandom(), 5'($urandom_range(31)), $urandom());
						1: issue(CMD_RDMEM, alias_addr(base + $urandom_range(len - 1)),
							5'($urandom_range(31)), $urandom());
						default: issue(CMD_EXEC, $urandom(), 5'($urandom_range(31)), $urandom());
					endcase
				end
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					issue(3'($urandom_range(7)), $urandom(), 5'($urandom_range(31)),
						$urandom());
				end
			end
		end
		req_ch.valid = 1'b0;

		// Drain the outstanding results, then let the core settle.
		while (rsp_due != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("** mips_subset_core_step_core: PASSED **");
		end else begin
			$display("** mips_subset_core_step_core: FAILED **");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5ms;
		$display("** mips_subset_core_step_core: FAILED **");
		$finish;
	end

endmodule
